FILE: hdl/rpn_pkg.sv
// Shared types and constants for the RPN stack evaluator.
// Used by rpn_stk_mem, rpn_alu and rpn_stack_evaluator_top; no dependencies.
package rpn_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PROD_W      = 2 * DATA_W;
    localparam int DVD_W       = DATA_W + FRAC_W;
    localparam int DIV_STEPS   = DVD_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    // token kinds
    localparam logic TOK_NUM = 1'b0;
    localparam logic TOK_OP  = 1'b1;

    // operator codes; the remaining codes are invalid operators
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_COUNT = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic                     start;
        logic [2:0]               op;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic                     done;
        logic                     bad_op;
        logic signed [DATA_W-1:0] result;
    } t_alu_rsp;

endpackage

FILE: hdl/rpn_stk_mem.sv
// Operand stack storage below the top-of-stack register.
// One write port, one read port with registered read data; uses rpn_pkg.
module rpn_stk_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [rpn_pkg::IDX_W-1:0]  i_waddr,
    input  logic [rpn_pkg::DATA_W-1:0] i_wdata,
    input  logic [rpn_pkg::IDX_W-1:0]  i_raddr,
    output logic [rpn_pkg::DATA_W-1:0] o_rdata
);
    import rpn_pkg::*;

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/rpn_alu.sv
// Shared Q16.16 arithmetic unit: saturating add/sub, registered multiply,
// and a bit-serial restoring divider. Uses rpn_pkg.
module rpn_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpn_pkg::t_alu_req i_req,
    output rpn_pkg::t_alu_rsp o_rsp
);
    import rpn_pkg::*;

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_MUL  = 5'b00010,
        A_DIV  = 5'b00100,
        A_FIX  = 5'b01000,
        A_DONE = 5'b10000
    } t_alu_state;

    t_alu_state r_state, n_state;

    logic signed [DATA_W-1:0] r_res;
    logic                     r_bad;
    logic signed [PROD_W-1:0] r_prod;
    logic [DVD_W-1:0]         r_dvd;
    logic [DATA_W-1:0]        r_rem;
    logic [DATA_W-1:0]        r_dsr;
    logic                     r_neg;
    logic [STEP_W-1:0]        r_step;

    logic [DATA_W:0]          w_sum;
    logic [DATA_W:0]          w_dif;
    logic [DATA_W-1:0]        w_mag_a;
    logic [DATA_W-1:0]        w_mag_b;
    logic signed [DVD_W-1:0]  w_mq;
    logic [DATA_W:0]          w_rem_sh;
    logic [DATA_W+1:0]        w_trial;
    logic                     w_last_step;

    assign w_sum = {i_req.a[DATA_W-1], i_req.a} + {i_req.b[DATA_W-1], i_req.b};
    assign w_dif = {i_req.a[DATA_W-1], i_req.a} - {i_req.b[DATA_W-1], i_req.b};
    assign w_mag_a = i_req.a[DATA_W-1] ? (~i_req.a + 1'b1) : i_req.a;
    assign w_mag_b = i_req.b[DATA_W-1] ? (~i_req.b + 1'b1) : i_req.b;
    // floor shift of the product
    assign w_mq = r_prod[PROD_W-1:FRAC_W];
    assign w_rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign w_trial = {1'b0, w_rem_sh} - {2'b00, r_dsr};
    assign w_last_step = (r_step == STEP_W'(DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == OP_MUL) begin
                        n_state = A_MUL;
                    end else if (i_req.op == OP_DIV && i_req.b != '0) begin
                        n_state = A_DIV;
                    end else begin
                        n_state = A_DONE;
                    end
                end
            end
            A_MUL:  n_state = A_DONE;
            A_DIV:  n_state = w_last_step ? A_FIX : A_DIV;
            A_FIX:  n_state = A_DONE;
            A_DONE: n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    r_bad  <= 1'b0;
                    r_prod <= i_req.a * i_req.b;
                    r_dvd  <= {w_mag_a, {FRAC_W{1'b0}}};
                    r_rem  <= '0;
                    r_dsr  <= w_mag_b;
                    r_neg  <= i_req.a[DATA_W-1] ^ i_req.b[DATA_W-1];
                    r_step <= '0;
                    unique case (i_req.op)
                        OP_ADD: begin
                            if (w_sum[DATA_W] != w_sum[DATA_W-1]) begin
                                r_res <= w_sum[DATA_W] ? Q_MIN : Q_MAX;
                            end else begin
                                r_res <= w_sum[DATA_W-1:0];
                            end
                        end
                        OP_SUB: begin
                            if (w_dif[DATA_W] != w_dif[DATA_W-1]) begin
                                r_res <= w_dif[DATA_W] ? Q_MIN : Q_MAX;
                            end else begin
                                r_res <= w_dif[DATA_W-1:0];
                            end
                        end
                        OP_MUL: r_res <= '0;
                        OP_DIV: begin
                            // divide by zero saturates by the dividend's sign
                            if (i_req.a[DATA_W-1]) begin
                                r_res <= Q_MIN;
                            end else if (i_req.a != '0) begin
                                r_res <= Q_MAX;
                            end else begin
                                r_res <= '0;
                            end
                        end
                        default: begin
                            r_res <= '0;
                            r_bad <= 1'b1;
                        end
                    endcase
                end
            end
            A_MUL: begin
                if (w_mq[DVD_W-1:DATA_W-1] != {(DVD_W-DATA_W+1){w_mq[DVD_W-1]}}) begin
                    r_res <= w_mq[DVD_W-1] ? Q_MIN : Q_MAX;
                end else begin
                    r_res <= w_mq[DATA_W-1:0];
                end
            end
            A_DIV: begin
                r_step <= r_step + 1'b1;
                if (!w_trial[DATA_W+1]) begin
                    r_rem <= w_trial[DATA_W-1:0];
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh[DATA_W-1:0];
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                end
            end
            A_FIX: begin
                // r_dvd now holds the quotient magnitude
                if (r_neg) begin
                    if ((|r_dvd[DVD_W-1:DATA_W]) ||
                        (r_dvd[DATA_W-1] && (|r_dvd[DATA_W-2:0]))) begin
                        r_res <= Q_MIN;
                    end else begin
                        r_res <= ~r_dvd[DATA_W-1:0] + 1'b1;
                    end
                end else begin
                    if (|r_dvd[DVD_W-1:DATA_W-1]) begin
                        r_res <= Q_MAX;
                    end else begin
                        r_res <= r_dvd[DATA_W-1:0];
                    end
                end
            end
            A_DONE: ;
            default: ;
        endcase
    end

    assign o_rsp.done   = (r_state == A_DONE);
    assign o_rsp.bad_op = r_bad;
    assign o_rsp.result = r_res;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == A_IDLE)
        else $error("alu started while busy");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == A_DIV) |-> r_step < STEP_W'(DIV_STEPS))
        else $error("divider step count overrun");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !o_rsp.done)
        else $error("alu done held longer than one cycle");

endmodule

FILE: hdl/rpn_stack_evaluator_top.sv
// RPN stack evaluator: one token per transaction, one result per expression.
// A number token, an operator with too few operands and any token after an
// error are handled in the idle state. Any other operator waits for the shared
// arithmetic unit: multiply registers the product first, and divide runs the
// bit-serial divider (one quotient bit per cycle over 48 bits, then a step to
// fix the sign) unless the divisor is zero. A token marked last adds a state
// to load the result register. The block takes no token while one is being
// worked on, but does take the next token while a finished result waits to
// be taken. Depends on rpn_pkg, rpn_stk_mem, rpn_alu.
module rpn_stack_evaluator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic signed [rpn_pkg::DATA_W-1:0] i_number_value,
    input  logic [2:0]                        i_op_code,
    input  logic                              i_last_token,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [rpn_pkg::DATA_W-1:0] o_result_value,
    output logic [1:0]                        o_status,
    output logic                              o_bad_operator_seen
);
    import rpn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]         r_count, n_count;
    logic [1:0]               r_err, n_err;
    logic                     r_warn, n_warn;
    logic signed [DATA_W-1:0] r_tos, n_tos;
    logic [2:0]               r_op;
    logic                     r_last;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic [1:0]               r_out_status;
    logic                     r_out_bad;

    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_load_out;
    logic [CNT_W-1:0]         w_cnt_m1;
    logic [CNT_W-1:0]         w_cnt_m2;
    logic                     w_we;
    logic [DATA_W-1:0]        w_rdata;
    t_alu_req                 w_alu_req;
    t_alu_rsp                 w_alu_rsp;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load_out = (r_state == S_FIN) && w_out_free;
    assign w_cnt_m1   = r_count - 1'b1;
    assign w_cnt_m2   = r_count - CNT_W'(2);

    // spill the old top into storage on a push
    assign w_we = w_accept && (r_err == ST_OK) && (i_req_type == TOK_NUM) &&
                  (r_count < CNT_W'(STACK_DEPTH)) && (r_count != '0);

    rpn_stk_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_cnt_m1[IDX_W-1:0]),
        .i_wdata (r_tos),
        .i_raddr (w_cnt_m2[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_alu_req.start = (r_state == S_READ);
    assign w_alu_req.op    = r_op;
    assign w_alu_req.a     = w_rdata;
    assign w_alu_req.b     = r_tos;

    rpn_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .o_rsp   (w_alu_rsp)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_err   = r_err;
        n_warn  = r_warn;
        n_tos   = r_tos;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_last_token ? S_FIN : S_IDLE;
                    if (r_err == ST_OK) begin
                        if (i_req_type == TOK_NUM) begin
                            if (r_count >= CNT_W'(STACK_DEPTH)) begin
                                n_err = ST_OVER;
                            end else begin
                                n_tos   = i_number_value;
                                n_count = r_count + 1'b1;
                            end
                        end else if (r_count < CNT_W'(2)) begin
                            n_err = ST_FEW;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (w_alu_rsp.done) begin
                    n_tos   = w_alu_rsp.result;
                    n_count = w_cnt_m1;
                    n_warn  = r_warn | w_alu_rsp.bad_op;
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_count = '0;
                    n_err   = ST_OK;
                    n_warn  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_warn      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_warn      <= n_warn;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos <= n_tos;
        if (w_accept) begin
            r_op   <= i_op_code;
            r_last <= i_last_token;
        end
        if (w_load_out) begin
            r_out_bad <= r_warn;
            if (r_err != ST_OK) begin
                r_out_value  <= '0;
                r_out_status <= r_err;
            end else if (r_count != CNT_W'(1)) begin
                r_out_value  <= '0;
                r_out_status <= ST_COUNT;
            end else begin
                r_out_value  <= r_tos;
                r_out_status <= ST_OK;
            end
        end
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_result_value      = r_out_value;
    assign o_status            = r_out_status;
    assign o_bad_operator_seen = r_out_bad;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_done_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_rsp.done |-> r_state == S_EXEC)
        else $error("alu result arrived outside execute");

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_count == '0 && r_err == ST_OK && r_out_valid))
        else $error("expression end did not clear the stack");

    a_err_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_err != ST_OK) |=> $stable(r_count) && $stable(r_err))
        else $error("stack changed after a latched error");

endmodule

FILE: tb/rpn_stack_evaluator_top_test.sv
`timescale 1ns / 1ps
// Testbench for rpn_stack_evaluator_top: directed and random token streams with
// random idling and output backpressure, checked against a stack predictor.
// Depends on rpn_pkg and the rpn_stack_evaluator_top RTL.
module rpn_stack_evaluator_top_test;
    import rpn_pkg::*;

    localparam int ONE          = 1 << FRAC_W;
    localparam int TOKEN_TARGET = 1550;
    localparam int IDLE_PCT     = 21;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
        logic                     bad_op;
    } t_expr_result;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_stall;
    logic                     i_req_type     = TOK_NUM;
    logic signed [DATA_W-1:0] i_number_value = '0;
    logic [2:0]               i_op_code      = OP_ADD;
    logic                     i_last_token   = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall    = 1'b0;
    logic signed [DATA_W-1:0] o_result_value;
    logic [1:0]               o_status;
    logic                     o_bad_operator_seen;

    // predictor state
    logic signed [DATA_W-1:0] eval_stack [STACK_DEPTH];
    int                       eval_depth = 0;
    logic [1:0]               eval_error = ST_OK;
    logic                     eval_warn  = 1'b0;
    t_expr_result             expected_results [$];

    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic rx_hold    = 1'b0;

    int tokens_sent    = 0;
    int exprs_sent     = 0;
    int divides_sent   = 0;
    int results_seen   = 0;
    int error_results  = 0;
    int fail_count     = 0;

    rpn_stack_evaluator_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_req_type          (i_req_type),
        .i_number_value      (i_number_value),
        .i_op_code           (i_op_code),
        .i_last_token        (i_last_token),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_result_value      (o_result_value),
        .o_status            (o_status),
        .o_bad_operator_seen (o_bad_operator_seen)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] saturate(input longint v);
        if (v > 64'sd2147483647) return Q_MAX;
        if (v < -64'sd2147483648) return Q_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] compute_op(
        input logic signed [DATA_W-1:0] lhs,
        input logic signed [DATA_W-1:0] rhs,
        input logic [2:0]               op
    );
        case (op)
            OP_ADD: return saturate(longint'(lhs) + longint'(rhs));
            OP_SUB: return saturate(longint'(lhs) - longint'(rhs));
            // arithmetic shift of the product rounds toward minus infinity
            OP_MUL: return saturate((longint'(lhs) * longint'(rhs)) >>> FRAC_W);
            OP_DIV: begin
                if (rhs == 0) begin
                    if (lhs > 0) return Q_MAX;
                    if (lhs < 0) return Q_MIN;
                    return '0;
                end
                return saturate((longint'(lhs) <<< FRAC_W) / longint'(rhs));
            end
            default: return '0;
        endcase
    endfunction

    // Advance the predicted stack by one accepted token.
    task automatic evaluate_token(
        input logic                     kind,
        input logic signed [DATA_W-1:0] num,
        input logic [2:0]               op,
        input logic                     last
    );
        t_expr_result             res;
        logic signed [DATA_W-1:0] lhs;
        logic signed [DATA_W-1:0] rhs;
        if (eval_error == ST_OK) begin
            if (kind == TOK_NUM) begin
                if (eval_depth >= STACK_DEPTH) begin
                    eval_error = ST_OVER;
                end else begin
                    eval_stack[eval_depth] = num;
                    eval_depth++;
                end
            end else if (eval_depth < 2) begin
                eval_error = ST_FEW;
            end else begin
                rhs = eval_stack[eval_depth-1];
                lhs = eval_stack[eval_depth-2];
                eval_depth--;
                eval_stack[eval_depth-1] = compute_op(lhs, rhs, op);
                if (op > OP_DIV) eval_warn = 1'b1;
            end
        end
        if (last) begin
            res.value  = '0;
            res.bad_op = eval_warn;
            if (eval_error != ST_OK) begin
                res.status = eval_error;
            end else if (eval_depth != 1) begin
                res.status = ST_COUNT;
            end else begin
                res.status = ST_OK;
                res.value  = eval_stack[0];
            end
            expected_results.push_back(res);
            exprs_sent++;
            eval_depth = 0;
            eval_error = ST_OK;
            eval_warn  = 1'b0;
        end
    endtask

    // Offer one token and hold it until the block takes it; call at a rising edge.
    task automatic send_token(
        input logic                     kind,
        input logic signed [DATA_W-1:0] num,
        input logic [2:0]               op,
        input logic                     last
    );
        // each idle cycle is inserted with the same chance
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= kind;
        i_number_value <= num;
        i_op_code      <= op;
        i_last_token   <= last;
        do @(posedge i_clk); while (o_in_stall);
        evaluate_token(kind, num, op, last);
        tokens_sent++;
        if (kind == TOK_OP && op == OP_DIV) divides_sent++;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_value();
        int span;
        span = 16 * ONE;
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3, 4:    return $urandom;
            default: return $signed($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    // Well-formed expression with the given number of operands.
    task automatic send_expression(input int operands, input int bad_pct);
        int         depth;
        int         pushed;
        logic [2:0] op;
        depth  = 0;
        pushed = 0;
        while (pushed < operands || depth > 1) begin
            if (depth >= 2 && (pushed == operands || $urandom_range(0, 1) == 1)) begin
                if ($urandom_range(0, 99) < bad_pct) op = 3'($urandom_range(4, 7));
                else op = 3'($urandom_range(0, 3));
                depth--;
                send_token(TOK_OP, $urandom, op, pushed == operands && depth == 1);
            end else begin
                pushed++;
                depth++;
                send_token(TOK_NUM, rand_value(), 3'($urandom),
                           pushed == operands && depth == 1);
            end
        end
    endtask

    // Random tokens in any order, closed by a last token.
    task automatic send_noise(input int count);
        repeat (count) begin
            send_token($urandom_range(0, 1) == 1, $urandom, 3'($urandom),
                       $urandom_range(0, 99) < 20);
        end
        send_token($urandom_range(0, 1) == 1, $urandom, 3'($urandom), 1'b1);
    endtask

    task automatic send_overflow(input int extra);
        repeat (STACK_DEPTH + extra - 1) send_token(TOK_NUM, rand_value(), 3'($urandom), 1'b0);
        send_token(TOK_NUM, rand_value(), 3'($urandom), 1'b1);
    endtask

    task automatic test_directed();
        send_token(TOK_NUM, Q_MAX, OP_ADD, 1'b1);
        // saturating add and subtract
        send_token(TOK_NUM, Q_MAX, OP_ADD, 1'b0);
        send_token(TOK_NUM, 1, OP_ADD, 1'b0);
        send_token(TOK_OP, '0, OP_ADD, 1'b1);
        send_token(TOK_NUM, Q_MIN, OP_ADD, 1'b0);
        send_token(TOK_NUM, 1, OP_ADD, 1'b0);
        send_token(TOK_OP, '1, OP_SUB, 1'b1);
        // negative product rounds down
        send_token(TOK_NUM, -1, OP_ADD, 1'b0);
        send_token(TOK_NUM, 1, OP_ADD, 1'b0);
        send_token(TOK_OP, '0, OP_MUL, 1'b1);
        send_token(TOK_NUM, ONE, OP_ADD, 1'b0);
        send_token(TOK_NUM, 3 * ONE, OP_ADD, 1'b0);
        send_token(TOK_OP, '0, OP_DIV, 1'b1);
        // divide by zero with positive, negative and zero dividends
        send_token(TOK_NUM, 5, OP_ADD, 1'b0);
        send_token(TOK_NUM, 0, OP_ADD, 1'b0);
        send_token(TOK_OP, '0, OP_DIV, 1'b1);
        send_token(TOK_NUM, -5, OP_ADD, 1'b0);
        send_token(TOK_NUM, 0, OP_ADD, 1'b0);
        send_token(TOK_OP, '0, OP_DIV, 1'b1);
        send_token(TOK_NUM, 0, OP_ADD, 1'b0);
        send_token(TOK_NUM, 0, OP_ADD, 1'b0);
        send_token(TOK_OP, '0, OP_DIV, 1'b1);
        // invalid operator, too few operands, wrong count at end
        send_token(TOK_NUM, ONE, OP_ADD, 1'b0);
        send_token(TOK_NUM, 2 * ONE, OP_ADD, 1'b0);
        send_token(TOK_OP, '0, 3'd6, 1'b1);
        send_token(TOK_OP, '0, OP_ADD, 1'b1);
        send_token(TOK_NUM, ONE, OP_ADD, 1'b0);
        send_token(TOK_NUM, ONE, OP_ADD, 1'b1);
        wait_for_results();
    endtask

    task automatic test_stack_limits();
        send_overflow(1);
        // warning set before an error survives it; tokens after the error are dropped
        send_token(TOK_NUM, ONE, OP_ADD, 1'b0);
        send_token(TOK_NUM, ONE, OP_ADD, 1'b0);
        send_token(TOK_OP, '0, 3'd7, 1'b0);
        send_token(TOK_OP, '0, OP_SUB, 1'b0);
        send_token(TOK_NUM, ONE, OP_ADD, 1'b1);
        send_expression(STACK_DEPTH, 0);
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        while (tokens_sent < 300) send_expression($urandom_range(1, 5), 5);
        wait_for_results();
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
    endtask

    task automatic test_output_backpressure();
        // hold the output long enough for the block to back up into its input
        fork
            begin
                rx_hold <= 1'b1;
                repeat (600) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (30) send_expression($urandom_range(1, 3), 10);
        wait_for_results();
    endtask

    task automatic test_random_expressions();
        int pick;
        while (tokens_sent < TOKEN_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) send_expression($urandom_range(1, 6), 5);
            else if (pick < 80) send_expression($urandom_range(7, STACK_DEPTH), 5);
            else if (pick < 87) send_expression($urandom_range(2, 6), 50);
            else if (pick < 96) send_noise($urandom_range(0, 6));
            else send_overflow($urandom_range(1, 3));
        end
        wait_for_results();
    endtask

    always @(posedge i_clk) begin
        if (rx_hold) i_out_stall <= 1'b1;
        else if (rx_idle_on) i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        else i_out_stall <= 1'b0;
    end

    always @(posedge i_clk) begin : result_check
        t_expr_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_status != ST_OK) error_results++;
            if (expected_results.size() == 0) begin
                $error("unexpected result: result_value %0d status %0d",
                       o_result_value, o_status);
                fail_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_result_value !== exp_res.value) begin
                    $error("result_value mismatch: expected %0d, actual %0d",
                           exp_res.value, o_result_value);
                    fail_count++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_res.status, o_status);
                    fail_count++;
                end
                if (o_bad_operator_seen !== exp_res.bad_op) begin
                    $error("bad_operator_seen mismatch: expected %0d, actual %0d",
                           exp_res.bad_op, o_bad_operator_seen);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_stack_limits();
        test_back_to_back();
        test_output_backpressure();
        test_random_expressions();
        repeat (64) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        $display("Sent %0d tokens in %0d expressions (%0d divides).",
                 tokens_sent, exprs_sent, divides_sent);
        $display("Checked %0d results, %0d of them with an error status.",
                 results_seen, error_results);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
